// ===== hdl/vector_angle_degrees_top_defines.svh =====
// Assertion macros used by the angle pipeline top module.
`ifndef VECTOR_ANGLE_DEGREES_TOP_DEFINES_SVH
`define VECTOR_ANGLE_DEGREES_TOP_DEFINES_SVH

// Checked on every clock edge once reset is released.
`define VAD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VAD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vad_pkg.sv =====
// Shared types, constants and the arctangent table of the vector angle pipeline.
package vad_pkg;

    localparam int COMP_W       = 16;
    localparam int ANGLE_FRAC   = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;

    localparam logic signed [33:0] DEG90_Q24  = 34'sd1509949440;
    localparam logic signed [33:0] DEG180_Q24 = 34'sd3019898880;

    // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest.
    localparam logic [31:0] ATAN_Q24 [CORDIC_STEPS] = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509719,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic invalid;  // one of the vectors is all zero
        logic neg;      // dot product is negative
    } side_t;

endpackage

// ===== hdl/vector_angle_degrees_top.sv =====
// Angle between a current and a reference 3-axis vector, in fixed-point degrees.
// Throughput is one transaction per cycle; the pipeline holds while its skid stage is full.
// The pipeline has 35 register stages: products, normalization, 16 root and 12 CORDIC stages.
// Reset clears all valid bits, output and skid flags included, asynchronously; data registers keep values.
`include "vector_angle_degrees_top_defines.svh"

module vector_angle_degrees_top
    import vad_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 8
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // cur_x, cur_y, cur_z, ref_x, ref_y, ref_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // angle_q8
    output logic        m_tuser    // invalid
);

    localparam int          SHR       = ANGLE_FRAC - FRACTION_BITS;
    localparam logic [32:0] RND       = 33'd1 << (SHR - 1);
    localparam logic [32:0] ANGLE_TOP = (33'd180 << FRACTION_BITS) > 33'hFFFF ?
                                        33'hFFFF : (33'd180 << FRACTION_BITS);

    logic               en;
    side_t              f_side, n_side, r_side, c_side;
    logic [63:0]        f_q, n_q;
    logic [31:0]        f_m, r_c;
    logic [59:0]        n_m, r_m;
    logic signed [33:0] c_z;
    logic [31:0]        zc;
    logic [32:0]        res;
    logic [15:0]        angle_next;
    logic               push;

    logic               out_valid_reg, skid_valid_reg;
    logic [15:0]        out_angle_reg, skid_angle_reg;
    logic               out_invalid_reg, skid_invalid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    vad_front #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .cur_x    (s_tdata[15:0]),
        .cur_y    (s_tdata[31:16]),
        .cur_z    (s_tdata[47:32]),
        .ref_x    (s_tdata[63:48]),
        .ref_y    (s_tdata[79:64]),
        .ref_z    (s_tdata[95:80]),
        .side     (f_side),
        .q        (f_q),
        .m        (f_m)
    );

    vad_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_side (f_side),
        .in_q    (f_q),
        .in_m    (f_m),
        .side    (n_side),
        .qs      (n_q),
        .ms      (n_m)
    );

    vad_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_side (n_side),
        .in_q    (n_q),
        .in_m    (n_m),
        .side    (r_side),
        .c       (r_c),
        .m       (r_m)
    );

    vad_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_side (r_side),
        .in_c    (r_c),
        .in_m    (r_m),
        .side    (c_side),
        .z       (c_z)
    );

    // Clamp to 0..180 degrees, round half up, then saturate to 16 bits; invalid items give zero.
    always_comb
    begin
        if (c_z < 0)
            zc = '0;
        else if (c_z > DEG180_Q24)
            zc = DEG180_Q24[31:0];
        else
            zc = c_z[31:0];
        res = (33'(zc) + RND) >> SHR;
        if (c_side.invalid)
            angle_next = '0;
        else if (res > 33'hFFFF)
            angle_next = 16'hFFFF;
        else
            angle_next = res[15:0];
    end

    assign push = en && c_side.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !m_tready)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !m_tready)
        begin
            if (push)
            begin
                skid_angle_reg   <= angle_next;
                skid_invalid_reg <= c_side.invalid;
            end
        end
        else if (skid_valid_reg)
        begin
            out_angle_reg   <= skid_angle_reg;
            out_invalid_reg <= skid_invalid_reg;
        end
        else if (push)
        begin
            out_angle_reg   <= angle_next;
            out_invalid_reg <= c_side.invalid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_angle_reg;
    assign m_tuser  = out_invalid_reg;

    `VAD_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full with empty output")
    `VAD_ASSERT(a_skid_fill, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready), "skid filled without a stalled output")
    `VAD_ASSERT(a_invalid_zero, out_valid_reg && out_invalid_reg |-> out_angle_reg == '0, "invalid transaction with nonzero angle")
    `VAD_ASSERT(a_angle_range, out_valid_reg |-> 33'(out_angle_reg) <= ANGLE_TOP, "angle above 180 degrees")

endmodule

// ===== hdl/vad_front.sv =====
// Front end: sign extension, dot and cross products, squared cross norm.
module vad_front
    import vad_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [COMP_W-1:0] cur_x,
    input  logic [COMP_W-1:0] cur_y,
    input  logic [COMP_W-1:0] cur_z,
    input  logic [COMP_W-1:0] ref_x,
    input  logic [COMP_W-1:0] ref_y,
    input  logic [COMP_W-1:0] ref_z,
    output side_t             side,
    output logic [63:0]       q,
    output logic [31:0]       m
);

    localparam int SH = COMP_W - COMPONENT_WIDTH;

    function automatic logic signed [COMP_W-1:0] sext(input logic [COMP_W-1:0] v);
        logic [COMP_W-1:0] t;
        t = v << SH;
        return $signed(t) >>> SH;
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    logic signed [COMP_W-1:0] a_next [3];
    logic signed [COMP_W-1:0] b_next [3];
    logic signed [COMP_W-1:0] a_reg  [3];
    logic signed [COMP_W-1:0] b_reg  [3];
    side_t                    sa_reg, sb_reg, sc_reg, sd_reg, se_reg;
    side_t                    sa_next, sc_next;
    logic signed [31:0]       p_reg  [9];
    logic signed [33:0]       dot_next;
    logic signed [32:0]       cr_next [3];
    logic [31:0]              cm_reg [3];
    logic [31:0]              mc_reg, md_reg, me_reg;
    logic [63:0]              sq_reg [3];
    logic [63:0]              q_reg;

    always_comb
    begin
        a_next[0] = sext(cur_x);
        a_next[1] = sext(cur_y);
        a_next[2] = sext(cur_z);
        b_next[0] = sext(ref_x);
        b_next[1] = sext(ref_y);
        b_next[2] = sext(ref_z);
        sa_next.valid   = in_valid;
        sa_next.invalid = (a_next[0] == '0 && a_next[1] == '0 && a_next[2] == '0) ||
                          (b_next[0] == '0 && b_next[1] == '0 && b_next[2] == '0);
        sa_next.neg     = 1'b0;
    end

    always_comb
    begin
        dot_next   = 34'(p_reg[0]) + 34'(p_reg[1]) + 34'(p_reg[2]);
        cr_next[0] = 33'(p_reg[3]) - 33'(p_reg[4]);
        cr_next[1] = 33'(p_reg[5]) - 33'(p_reg[6]);
        cr_next[2] = 33'(p_reg[7]) - 33'(p_reg[8]);
        sc_next     = sb_reg;
        sc_next.neg = dot_next[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg <= '0;
            sb_reg <= '0;
            sc_reg <= '0;
            sd_reg <= '0;
            se_reg <= '0;
        end
        else if (en)
        begin
            sa_reg <= sa_next;
            sb_reg <= sa_reg;
            sc_reg <= sc_next;
            sd_reg <= sc_reg;
            se_reg <= sd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            p_reg[0] <= a_reg[0] * b_reg[0];
            p_reg[1] <= a_reg[1] * b_reg[1];
            p_reg[2] <= a_reg[2] * b_reg[2];
            p_reg[3] <= a_reg[1] * b_reg[2];
            p_reg[4] <= a_reg[2] * b_reg[1];
            p_reg[5] <= a_reg[2] * b_reg[0];
            p_reg[6] <= a_reg[0] * b_reg[2];
            p_reg[7] <= a_reg[0] * b_reg[1];
            p_reg[8] <= a_reg[1] * b_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                cm_reg[i] <= mag33(cr_next[i]);
                sq_reg[i] <= 64'(cm_reg[i]) * 64'(cm_reg[i]);
            end
            mc_reg <= dot_next[33] ? 32'(-dot_next) : dot_next[31:0];
            md_reg <= mc_reg;
            // The squared cross norm never exceeds |A|^2 |B|^2, which fits 64 bits.
            q_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            me_reg <= md_reg;
        end
    end

    assign side = se_reg;
    assign q    = q_reg;
    assign m    = me_reg;

endmodule

// ===== hdl/vad_norm.sv =====
// Normalization: scales the squared cross norm by 4^k and the dot magnitude by 2^k.
module vad_norm
    import vad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  side_t       in_side,
    input  logic [63:0] in_q,
    input  logic [31:0] in_m,
    output side_t       side,
    output logic [63:0] qs,
    output logic [59:0] ms
);

    side_t       sf_reg, sg_reg;
    logic [63:0] qf_reg, qs_reg;
    logic [31:0] mf_reg;
    logic [59:0] ms_reg;
    logic [6:0]  blq_reg, blq_next;
    logic [5:0]  blm_reg, blm_next;
    logic [5:0]  kq, km, k;

    always_comb
    begin
        blq_next = '0;
        blm_next = '0;
        for (int i = 0; i < 64; i++)
            if (in_q[i])
                blq_next = 7'(i + 1);
        for (int i = 0; i < 32; i++)
            if (in_m[i])
                blm_next = 6'(i + 1);
    end

    // Shifting stops at the first k with q*4^k >= 2^60 or m*2^k >= 2^59, or at 32.
    always_comb
    begin
        if (blq_reg == '0)
            kq = 6'd32;
        else if (blq_reg >= 7'd61)
            kq = '0;
        else
            kq = 6'((7'd62 - blq_reg) >> 1);
        if (blm_reg == '0)
            km = 6'd32;
        else
            km = 6'(7'd60 - 7'(blm_reg));
        k = (kq < km) ? kq : km;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg <= '0;
            sg_reg <= '0;
        end
        else if (en)
        begin
            sf_reg <= in_side;
            sg_reg <= sf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qf_reg  <= in_q;
            mf_reg  <= in_m;
            blq_reg <= blq_next;
            blm_reg <= blm_next;
            qs_reg  <= qf_reg << {k, 1'b0};
            ms_reg  <= 60'(mf_reg) << k;
        end
    end

    assign side = sg_reg;
    assign qs   = qs_reg;
    assign ms   = ms_reg;

endmodule

// ===== hdl/vad_sqrt.sv =====
// Integer square root, two result bits per pipeline stage.
module vad_sqrt
    import vad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  side_t       in_side,
    input  logic [63:0] in_q,
    input  logic [59:0] in_m,
    output side_t       side,
    output logic [31:0] c,
    output logic [59:0] m
);

    localparam int STAGES = SQRT_STEPS / 2;

    side_t       s_reg [STAGES];
    logic [63:0] v_reg [STAGES];
    logic [63:0] r_reg [STAGES];
    logic [59:0] m_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        side_t       s_prev;
        logic [63:0] v_prev, r_prev, v_next, r_next, bb, vt, rt;
        logic [59:0] m_prev;

        if (s == 0)
        begin : g_first
            assign s_prev = in_side;
            assign v_prev = in_q;
            assign r_prev = '0;
            assign m_prev = in_m;
        end
        else
        begin : g_rest
            assign s_prev = s_reg[s-1];
            assign v_prev = v_reg[s-1];
            assign r_prev = r_reg[s-1];
            assign m_prev = m_reg[s-1];
        end

        always_comb
        begin
            vt = v_prev;
            rt = r_prev;
            for (int t = 0; t < 2; t++)
            begin
                bb = 64'd1 << (62 - 2 * (2 * s + t));
                if (vt >= rt + bb)
                begin
                    vt = vt - (rt + bb);
                    rt = (rt >> 1) + bb;
                end
                else
                begin
                    rt = rt >> 1;
                end
            end
            v_next = vt;
            r_next = rt;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_reg[s] <= '0;
            else if (en)
                s_reg[s] <= s_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s] <= v_next;
                r_reg[s] <= r_next;
                m_reg[s] <= m_prev;
            end
        end
    end

    assign side = s_reg[STAGES-1];
    assign c    = r_reg[STAGES-1][31:0];
    assign m    = m_reg[STAGES-1];

endmodule

// ===== hdl/vad_cordic.sv =====
// CORDIC vectoring in degrees, two rotations per pipeline stage.
module vad_cordic
    import vad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  side_t              in_side,
    input  logic [31:0]        in_c,
    input  logic [59:0]        in_m,
    output side_t              side,
    output logic signed [33:0] z
);

    localparam int STAGES = CORDIC_STEPS / 2;

    side_t              s_reg [STAGES];
    logic signed [63:0] x_reg [STAGES];
    logic signed [63:0] y_reg [STAGES];
    logic signed [33:0] z_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        side_t              s_prev;
        logic signed [63:0] x_prev, y_prev, x_next, y_next, xt, yt, nx;
        logic signed [33:0] z_prev, z_next, zt, da;

        if (s == 0)
        begin : g_first
            // A negative dot product starts from 90 degrees with the roles swapped.
            assign s_prev = in_side;
            assign x_prev = in_side.neg ? 64'(in_c) : 64'(in_m);
            assign y_prev = in_side.neg ? 64'(in_m) : 64'(in_c);
            assign z_prev = in_side.neg ? DEG90_Q24 : '0;
        end
        else
        begin : g_rest
            assign s_prev = s_reg[s-1];
            assign x_prev = x_reg[s-1];
            assign y_prev = y_reg[s-1];
            assign z_prev = z_reg[s-1];
        end

        always_comb
        begin
            xt = x_prev;
            yt = y_prev;
            zt = z_prev;
            for (int t = 0; t < 2; t++)
            begin
                da = $signed({2'b00, ATAN_Q24[2 * s + t]});
                if (yt > 0)
                begin
                    nx = xt + (yt >>> (2 * s + t));
                    yt = yt - (xt >>> (2 * s + t));
                    zt = zt + da;
                end
                else
                begin
                    nx = xt - (yt >>> (2 * s + t));
                    yt = yt + (xt >>> (2 * s + t));
                    zt = zt - da;
                end
                xt = nx;
            end
            x_next = xt;
            y_next = yt;
            z_next = zt;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_reg[s] <= '0;
            else if (en)
                s_reg[s] <= s_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s] <= x_next;
                y_reg[s] <= y_next;
                z_reg[s] <= z_next;
            end
        end
    end

    assign side = s_reg[STAGES-1];
    assign z    = z_reg[STAGES-1];

endmodule
